// File: rtl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

    // frame geometry
    localparam int NUM_CH    = 16;
    localparam int RAW_W     = 11;
    localparam int PAY_BYTES = 22;
    localparam int PAY_W     = PAY_BYTES * 8;
    localparam int POS_W     = 5;
    localparam int CH_W      = 4;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // parser positions (1-based slot of the byte after the header)
    localparam logic [POS_W-1:0] POS_HUNT     = 5'd0;
    localparam logic [POS_W-1:0] POS_FIRST    = 5'd1;
    localparam logic [POS_W-1:0] POS_LAST_PAY = 5'd22;
    localparam logic [POS_W-1:0] POS_FLAG     = 5'd23;
    localparam logic [POS_W-1:0] POS_FOOT     = 5'd24;

    // divider: 23-bit dividend magnitude, one quotient bit per cycle
    localparam int QUO_W = 23;
    localparam int DEN_W = 11;
    localparam logic [4:0] DIV_LAST = 5'd22;

    localparam logic [CH_W-1:0] CH_LAST = 4'd15;

    // flag byte bits
    localparam int FLAG_LOST_BIT = 2;
    localparam int FLAG_FS_BIT   = 3;

    // register map indexes
    localparam logic [2:0] REG_HEADER   = 3'd0;
    localparam logic [2:0] REG_FOOTER   = 3'd1;
    localparam logic [2:0] REG_ALT_VAL  = 3'd2;
    localparam logic [2:0] REG_ALT_MASK = 3'd3;
    localparam logic [2:0] REG_RAW_MIN  = 3'd4;
    localparam logic [2:0] REG_RAW_MAX  = 3'd5;
    localparam logic [2:0] REG_OUT_MIN  = 3'd6;
    localparam logic [2:0] REG_OUT_MAX  = 3'd7;

    // register reset values
    localparam logic [7:0]  RST_HEADER   = 8'd15;
    localparam logic [7:0]  RST_FOOTER   = 8'd0;
    localparam logic [7:0]  RST_ALT_VAL  = 8'd4;
    localparam logic [7:0]  RST_ALT_MASK = 8'd15;
    localparam logic [10:0] RST_RAW_MIN  = 11'd173;
    localparam logic [10:0] RST_RAW_MAX  = 11'd1811;
    localparam logic [11:0] RST_OUT_MIN  = 12'd1000;
    localparam logic [11:0] RST_OUT_MAX  = 12'd2000;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  footer_byte;
        logic [7:0]  footer_alt_value;
        logic [7:0]  footer_alt_mask;
        logic [10:0] raw_min;
        logic [10:0] raw_max;
        logic [11:0] out_min;
        logic [11:0] out_max;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic            upd_prev;
        logic            shift;
        logic            flag_st;
        logic            frame_go;
        logic            ch_load;
        logic            mul;
        logic            dinit;
        logic            dstep;
        logic            push;
        logic [CH_W-1:0] ch_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic prev_foot;
        logic in_hdr;
        logic in_foot;
        logic out_free;
    } sts_t;

    function automatic logic is_footer(input logic [7:0] b, input cfg_t c);
        is_footer = (b == c.footer_byte) ||
                    ((b & c.footer_alt_mask) == c.footer_alt_value);
    endfunction

endpackage
`default_nettype wire

// File: rtl/sfd_ifs.sv
`default_nettype none
// received byte channel
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// decoded channel result channel
interface sfd_chan_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel_index;
    logic signed [15:0] channel_value;
    logic               signal_lost;
    logic               failsafe;
    logic               last;
    modport source (output valid, output channel_index, output channel_value,
                    output signal_lost, output failsafe, output last, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input signal_lost, input failsafe, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/sfd_regs.sv
`default_nettype none
module sfd_regs
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfd_pkg::DATA_W-1:0] pwdata,
    output logic      [sfd_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output sfd_pkg::cfg_t                  cfg
);
    import sfd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // write decode, values masked to register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_HEADER:   cfg_next.header_byte      = pwdata[7:0];
                REG_FOOTER:   cfg_next.footer_byte      = pwdata[7:0];
                REG_ALT_VAL:  cfg_next.footer_alt_value = pwdata[7:0];
                REG_ALT_MASK: cfg_next.footer_alt_mask  = pwdata[7:0];
                REG_RAW_MIN:  cfg_next.raw_min          = pwdata[10:0];
                REG_RAW_MAX:  cfg_next.raw_max          = pwdata[10:0];
                REG_OUT_MIN:  cfg_next.out_min          = pwdata[11:0];
                REG_OUT_MAX:  cfg_next.out_max          = pwdata[11:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte      <= RST_HEADER;
            cfg_reg.footer_byte      <= RST_FOOTER;
            cfg_reg.footer_alt_value <= RST_ALT_VAL;
            cfg_reg.footer_alt_mask  <= RST_ALT_MASK;
            cfg_reg.raw_min          <= RST_RAW_MIN;
            cfg_reg.raw_max          <= RST_RAW_MAX;
            cfg_reg.out_min          <= RST_OUT_MIN;
            cfg_reg.out_max          <= RST_OUT_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_HEADER:   prdata = {24'b0, cfg_reg.header_byte};
            REG_FOOTER:   prdata = {24'b0, cfg_reg.footer_byte};
            REG_ALT_VAL:  prdata = {24'b0, cfg_reg.footer_alt_value};
            REG_ALT_MASK: prdata = {24'b0, cfg_reg.footer_alt_mask};
            REG_RAW_MIN:  prdata = {21'b0, cfg_reg.raw_min};
            REG_RAW_MAX:  prdata = {21'b0, cfg_reg.raw_max};
            REG_OUT_MIN:  prdata = {20'b0, cfg_reg.out_min};
            REG_OUT_MAX:  prdata = {20'b0, cfg_reg.out_max};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/sfd_ctrl.sv
`default_nettype none
module sfd_ctrl
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   rx_valid,
    output logic        rx_ready,
    input  wire sfd_pkg::sts_t sts,
    output sfd_pkg::cmd_t cmd
);
    import sfd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DINIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [4:0]       dcnt_reg, dcnt_next;
    logic             acc;
    logic             frame_go;

    // footer beat is held off while the previous frame is still mapped
    assign rx_ready = !((state_reg != S_IDLE) && (pos_reg == POS_FOOT));
    assign acc      = rx_valid && rx_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.ch_idx = ch_reg;
        state_next = state_reg;
        pos_next   = pos_reg;
        ch_next    = ch_reg;
        dcnt_next  = dcnt_reg;
        frame_go   = 1'b0;

        // byte parser
        if (acc)
        begin
            cmd.upd_prev = 1'b1;
            if (pos_reg == POS_HUNT)
            begin
                if (sts.in_hdr && sts.prev_foot)
                    pos_next = POS_FIRST;
            end
            else
            begin
                if (pos_reg <= POS_LAST_PAY)
                    cmd.shift = 1'b1;
                if (pos_reg == POS_FLAG)
                    cmd.flag_st = 1'b1;
                if (pos_reg == POS_FOOT)
                begin
                    pos_next = POS_HUNT;
                    frame_go = sts.in_foot;
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
        end
        cmd.frame_go = frame_go;

        // channel sequencer
        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_go)
                begin
                    ch_next    = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.ch_load = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.dinit  = 1'b1;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.dstep = 1'b1;
                if (dcnt_reg == DIV_LAST)
                    state_next = S_PUSH;
                else
                    dcnt_next = dcnt_reg + 5'd1;
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push = 1'b1;
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 4'd1;
                        state_next = S_LOAD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= POS_HUNT;
            ch_reg    <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ch_reg    <= ch_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // checks
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        frame_go |=> (state_reg == S_LOAD) && (ch_reg == '0))
        else $error("frame start did not begin at channel zero");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FOOT)
        else $error("parser position out of range");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (dcnt_reg == DIV_LAST) |=> state_reg == S_PUSH)
        else $error("divider did not finish after its last step");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sts.out_free)
        else $error("result pushed over a pending beat");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> (state_reg != S_IDLE) && (pos_reg == POS_FOOT))
        else $error("input stalled without a frame in progress");

endmodule
`default_nettype wire

// File: rtl/sfd_dp.sv
`default_nettype none
module sfd_dp
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire sfd_pkg::cfg_t cfg,
    input  wire logic [7:0] rx_byte,
    input  wire sfd_pkg::cmd_t cmd,
    output sfd_pkg::sts_t sts,
    sfd_chan_if.source  chan
);
    import sfd_pkg::*;

    // byte capture
    logic [7:0]       prev_reg;
    logic [PAY_W-1:0] pay_reg;
    logic [1:0]       flag_reg;
    // per-frame unpack copy
    logic [PAY_W-1:0] unp_reg;
    logic [1:0]       uflag_reg;
    // mapping pipeline
    logic signed [11:0] diff_reg;
    logic signed [12:0] scale_reg;
    logic signed [11:0] den_reg;
    logic signed [24:0] prod_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   dmag_reg;
    logic               neg_reg;
    // result beat
    logic               ovld_reg;
    logic [CH_W-1:0]    oidx_reg;
    logic [15:0]        oval_reg;
    logic               olost_reg;
    logic               ofs_reg;
    logic               olast_reg;

    logic [11:0]        rem_sh;
    logic               qbit;
    logic signed [23:0] qs;
    logic [24:0]        sum;
    logic [15:0]        sat;

    assign sts.prev_foot = is_footer(prev_reg, cfg);
    assign sts.in_hdr    = (rx_byte == cfg.header_byte);
    assign sts.in_foot   = is_footer(rx_byte, cfg);
    assign sts.out_free  = !ovld_reg || chan.ready;

    // byte store: payload shifts in from the top, byte 0 ends at the bottom
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
            pay_reg <= {rx_byte, pay_reg[PAY_W-1:8]};
        if (cmd.flag_st)
            flag_reg <= {rx_byte[FLAG_FS_BIT], rx_byte[FLAG_LOST_BIT]};
        if (cmd.frame_go)
        begin
            unp_reg   <= pay_reg;
            uflag_reg <= flag_reg;
        end
        else if (cmd.ch_load)
        begin
            unp_reg <= {{RAW_W{1'b0}}, unp_reg[PAY_W-1:RAW_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= '0;
        else if (cmd.upd_prev)
            prev_reg <= rx_byte;
    end

    // divider step: restoring, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[QUO_W-1]};
    assign qbit   = (rem_sh >= {1'b0, dmag_reg});

    // offset, round-toward-zero sign and saturation
    assign qs  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign sum = (den_reg == '0) ? {13'b0, cfg.out_min}
                                 : ({qs[23], qs} + {13'b0, cfg.out_min});
    always_comb
    begin
        if ($signed(sum) > 25'sd32767)
            sat = 16'h7FFF;
        else if ($signed(sum) < -25'sd32768)
            sat = 16'h8000;
        else
            sat = sum[15:0];
    end

    always_ff @(posedge clk)
    begin
        // raw channel minus offsets
        if (cmd.ch_load)
        begin
            diff_reg  <= $signed({1'b0, unp_reg[RAW_W-1:0]} - {1'b0, cfg.raw_min});
            scale_reg <= $signed({1'b0, cfg.out_max} - {1'b0, cfg.out_min});
            den_reg   <= $signed({1'b0, cfg.raw_max} - {1'b0, cfg.raw_min});
        end
        if (cmd.mul)
            prod_reg <= diff_reg * scale_reg;
        // load magnitudes into the divider
        if (cmd.dinit)
        begin
            quo_reg  <= prod_reg[24] ? QUO_W'(-prod_reg) : QUO_W'(prod_reg);
            dmag_reg <= den_reg[11] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
            neg_reg  <= prod_reg[24] ^ den_reg[11];
            rem_reg  <= '0;
        end
        else if (cmd.dstep)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
            rem_reg <= qbit ? DEN_W'(rem_sh - {1'b0, dmag_reg}) : DEN_W'(rem_sh);
        end
        // result payload
        if (cmd.push)
        begin
            oidx_reg  <= cmd.ch_idx;
            oval_reg  <= sat;
            olost_reg <= uflag_reg[0];
            ofs_reg   <= uflag_reg[1];
            olast_reg <= (cmd.ch_idx == CH_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (cmd.push)
            ovld_reg <= 1'b1;
        else if (chan.ready)
            ovld_reg <= 1'b0;
    end

    assign chan.valid         = ovld_reg;
    assign chan.channel_index = oidx_reg;
    assign chan.channel_value = $signed(oval_reg);
    assign chan.signal_lost   = olost_reg;
    assign chan.failsafe      = ofs_reg;
    assign chan.last          = olast_reg;

endmodule
`default_nettype wire

// File: rtl/sbus_frame_decoder_core.sv
// Byte side: one byte per cycle; the footer beat of a frame waits while the previous
// frame's sixteen channels are still being mapped.
// Each channel steps through load, multiply, divider setup, 23 divider steps and the
// result beat, which waits while the previous beat is still pending.
// Mapping starts at channel zero once the valid footer byte is taken.
// Reset: registers return to defaults, parser hunts with previous byte zero, no beat.
`default_nettype none
module sbus_frame_decoder_core
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    sfd_byte_if.sink                        rx,
    sfd_chan_if.source                      chan,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfd_pkg::DATA_W-1:0] pwdata,
    output logic      [sfd_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import sfd_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // configuration registers
    sfd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parser and channel sequencer
    sfd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // byte store, mapping arithmetic and result register
    sfd_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .rx_byte (rx.rx_byte),
        .cmd     (cmd),
        .sts     (sts),
        .chan    (chan)
    );

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 500;   // one full frame of mapping plus margin
    localparam int PHASE_ITEMS   = 40;
    localparam int NUM_PHASES    = 6;
    localparam int FRAME_BYTES   = 24;
    localparam int FLAG_SLOT     = 22;

    typedef enum int { FRAME_GOOD, FRAME_BAD_FOOTER, FRAME_CUT } frame_kind_t;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [15:0] value;
        logic               lost;
        logic               fs;
        logic               last;
    } chan_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    sfd_byte_if rx_if ();
    sfd_chan_if chan_if ();

    sbus_frame_decoder_core DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .chan    (chan_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder model state
    cfg_t         cur_cfg;
    logic [7:0]   last_byte;
    int           frame_slot;
    logic [7:0]   frame_bytes [FRAME_BYTES];

    logic [7:0]   byte_queue [$];
    chan_result_t chan_expect_q [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int error_count;
    int beats_checked;
    int frames_decoded;
    int frames_dropped;
    int bytes_sent;
    int queued_items;
    int cycle_count;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic footer_match(input logic [7:0] b, input cfg_t c);
        return (b == c.footer_byte) ||
               ((b & c.footer_alt_mask) == c.footer_alt_value);
    endfunction

    // linear map with truncating division, saturated to 16-bit signed
    function automatic logic signed [15:0] scale_raw(input logic [10:0] raw);
        longint r, rmin, rmax, omin, omax, span, v;
        r    = raw;
        rmin = cur_cfg.raw_min;
        rmax = cur_cfg.raw_max;
        omin = cur_cfg.out_min;
        omax = cur_cfg.out_max;
        span = rmax - rmin;
        if (span == 0)
            v = omin;
        else
            v = ((r - rmin) * (omax - omin)) / span + omin;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // parser step for one accepted byte beat
    task automatic decode_byte(input logic [7:0] b);
        logic [PAY_W-1:0] pay_bits;
        logic [7:0]       flags;
        chan_result_t     res;
        if (frame_slot == 0)
        begin
            if (b == cur_cfg.header_byte && footer_match(last_byte, cur_cfg))
                frame_slot = 1;
        end
        else
        begin
            frame_bytes[frame_slot - 1] = b;
            frame_slot++;
            if (frame_slot > FRAME_BYTES)
            begin
                frame_slot = 0;
                if (footer_match(b, cur_cfg))
                begin
                    for (int i = 0; i < PAY_BYTES; i++)
                        pay_bits[8*i +: 8] = frame_bytes[i];
                    flags = frame_bytes[FLAG_SLOT];
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        res.idx   = ch[3:0];
                        res.value = scale_raw(pay_bits[ch*RAW_W +: RAW_W]);
                        res.lost  = flags[FLAG_LOST_BIT];
                        res.fs    = flags[FLAG_FS_BIT];
                        res.last  = (ch == NUM_CH - 1);
                        chan_expect_q.push_back(res);
                    end
                    frames_decoded++;
                end
                else
                begin
                    frames_dropped++;
                end
            end
        end
        last_byte = b;
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_if.valid <= 1'b0;
        end
        else
        begin
            if (rx_if.valid && rx_if.ready)
            begin
                decode_byte(rx_if.rx_byte);
                bytes_sent++;
            end
            if (!rx_if.valid || rx_if.ready)
            begin
                if (byte_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= byte_queue.pop_front();
                end
                else
                begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_beat();
        chan_result_t want;
        if (chan_expect_q.size() == 0)
        begin
            $error("unexpected channel beat: index %0d value %0d",
                   chan_if.channel_index, chan_if.channel_value);
            error_count++;
        end
        else
        begin
            want = chan_expect_q.pop_front();
            beats_checked++;
            if (chan_if.channel_index !== want.idx)
            begin
                $error("channel_index: expected %0d, got %0d", want.idx, chan_if.channel_index);
                error_count++;
            end
            if (chan_if.channel_value !== want.value)
            begin
                $error("channel_value: expected %0d, got %0d", want.value, chan_if.channel_value);
                error_count++;
            end
            if (chan_if.signal_lost !== want.lost)
            begin
                $error("signal_lost: expected %0d, got %0d", want.lost, chan_if.signal_lost);
                error_count++;
            end
            if (chan_if.failsafe !== want.fs)
            begin
                $error("failsafe: expected %0d, got %0d", want.fs, chan_if.failsafe);
                error_count++;
            end
            if (chan_if.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, chan_if.last);
                error_count++;
            end
        end
    endtask

    // channel monitor, random backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            chan_if.ready <= 1'b0;
        end
        else
        begin
            chan_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            if (chan_if.valid && chan_if.ready)
                check_beat();
        end
    end

    // APB write: setup then access, register taken on the access edge
    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input cfg_t c);
        reg_write(REG_HEADER,   DATA_W'(c.header_byte));
        reg_write(REG_FOOTER,   DATA_W'(c.footer_byte));
        reg_write(REG_ALT_VAL,  DATA_W'(c.footer_alt_value));
        reg_write(REG_ALT_MASK, DATA_W'(c.footer_alt_mask));
        reg_write(REG_RAW_MIN,  DATA_W'(c.raw_min));
        reg_write(REG_RAW_MAX,  DATA_W'(c.raw_max));
        reg_write(REG_OUT_MIN,  DATA_W'(c.out_min));
        reg_write(REG_OUT_MAX,  DATA_W'(c.out_max));
        @(negedge clk);
        cur_cfg = c;
    endtask

    function automatic cfg_t make_cfg(input logic [7:0] h, f, av, am,
                                      input logic [10:0] rmin, rmax,
                                      input logic [11:0] omin, omax);
        cfg_t c;
        c.header_byte      = h;
        c.footer_byte      = f;
        c.footer_alt_value = av;
        c.footer_alt_mask  = am;
        c.raw_min          = rmin;
        c.raw_max          = rmax;
        c.out_min          = omin;
        c.out_max          = omax;
        return c;
    endfunction

    // random settings; header kept off the footer set so frames can lock
    function automatic cfg_t random_cfg();
        cfg_t c;
        c.footer_byte      = 8'($urandom_range(0, 255));
        c.footer_alt_mask  = 8'($urandom_range(0, 255));
        c.footer_alt_value = 8'($urandom_range(0, 255)) & c.footer_alt_mask;
        c.raw_min          = 11'($urandom_range(0, 2047));
        c.raw_max          = 11'($urandom_range(0, 2047));
        c.out_min          = 12'($urandom_range(0, 4095));
        c.out_max          = 12'($urandom_range(0, 4095));
        c.header_byte      = 8'($urandom_range(0, 255));
        for (int t = 0; t < 64 && footer_match(c.header_byte, c); t++)
            c.header_byte = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] good_footer();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 1 &&
            (cur_cfg.footer_alt_value & ~cur_cfg.footer_alt_mask) == 8'h00)
            b = (8'($urandom_range(0, 255)) & ~cur_cfg.footer_alt_mask) |
                cur_cfg.footer_alt_value;
        else
            b = cur_cfg.footer_byte;
        return b;
    endfunction

    function automatic logic [7:0] bad_footer();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        for (int t = 0; t < 64 && footer_match(b, cur_cfg); t++)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic push_item(input logic [7:0] b);
        byte_queue.push_back(b);
        queued_items++;
    endtask

    // one frame, optionally preceded by a footer so the hunt can lock
    task automatic queue_frame(input frame_kind_t kind);
        int fill;
        int n_bytes;
        if ($urandom_range(0, 1) == 1)
            push_item(good_footer());
        push_item(cur_cfg.header_byte);
        fill    = $urandom_range(0, 5);
        n_bytes = (kind == FRAME_CUT) ? $urandom_range(1, 20) : PAY_BYTES;
        for (int i = 0; i < n_bytes; i++)
        begin
            case (fill)
                0: push_item(8'h00);
                1: push_item(8'hFF);
                default:
                    if ($urandom_range(0, 7) == 0)
                        push_item(cur_cfg.header_byte);
                    else
                        push_item(8'($urandom_range(0, 255)));
            endcase
        end
        if (kind != FRAME_CUT)
        begin
            push_item(8'($urandom_range(0, 255)));
            if (kind == FRAME_GOOD)
                push_item(good_footer());
            else
                push_item(bad_footer());
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (byte_queue.size() != 0 || rx_if.valid || chan_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic gen_phase(input int target, input bit pause_mid);
        int start;
        int pick;
        bit paused;
        start  = queued_items;
        paused = 1'b0;
        while (queued_items - start < target)
        begin
            // hold the byte side until every pending channel beat is out
            if (pause_mid && !paused && queued_items - start >= target / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 68)
                queue_frame(FRAME_GOOD);
            else if (pick < 80)
                queue_frame(FRAME_BAD_FOOTER);
            else if (pick < 88)
                queue_frame(FRAME_CUT);
            else
                repeat ($urandom_range(1, 6))
                    push_item(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        cfg_t settings [NUM_PHASES];

        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        chan_if.ready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cycle_count   = 0;
        error_count   = 0;
        beats_checked = 0;
        frames_decoded = 0;
        frames_dropped = 0;
        bytes_sent    = 0;
        queued_items  = 0;
        tx_idle_pct   = 7;
        rx_idle_pct   = 73;
        last_byte     = 8'h00;
        frame_slot    = 0;
        cur_cfg = make_cfg(RST_HEADER, RST_FOOTER, RST_ALT_VAL, RST_ALT_MASK,
                           RST_RAW_MIN, RST_RAW_MAX, RST_OUT_MIN, RST_OUT_MAX);

        // bounds at both ends, inverted range, saturation, equal raw bounds, random
        settings[0] = make_cfg(8'hFF, 8'h00, 8'h00, 8'hFF, 11'd0, 11'd2047, 12'd0, 12'd4095);
        settings[1] = make_cfg(8'h00, 8'hFF, 8'hA0, 8'hF0, 11'd2047, 11'd0, 12'd4095, 12'd0);
        settings[2] = make_cfg(8'h5A, 8'hA5, 8'h03, 8'h03, 11'd1000, 11'd1001,
                               12'd0, 12'd4095);
        settings[3] = make_cfg(8'h0F, 8'hF0, 8'h01, 8'h00, 11'd777, 11'd777, 12'd4095, 12'd0);
        settings[4] = random_cfg();
        settings[5] = random_cfg();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frame at reset settings: the reset previous byte already counts
        // as a footer, zero and all-ones channels, a header byte inside the
        // payload, both flag bits set, alternate footer form
        push_item(RST_HEADER);
        repeat (5) push_item(8'h00);
        repeat (6) push_item(8'hFF);
        push_item(RST_HEADER);
        repeat (10) push_item(8'($urandom_range(0, 255)));
        push_item(8'h0C);
        push_item(8'h24);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            apply_settings(settings[p]);
            if (p == 2)
            begin
                tx_idle_pct = 73;
                rx_idle_pct = 7;
            end
            else if (p == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            gen_phase(PHASE_ITEMS, p == 2);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: %0d frames decoded, %0d dropped on a bad footer, %0d beats checked",
                 bytes_sent, frames_decoded, frames_dropped, beats_checked);
        $display("Register sets: reset, full range, inverted range, saturating, flat, 2 random");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
